// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b in the same cycle
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== rtl/tlrc_pkg.sv =====
package tlrc_pkg;

  localparam int CW    = 20;  // CORDIC datapath width
  localparam int SW    = 34;  // square root datapath width
  localparam int STEPS = 17;

  localparam logic [16:0] CORDIC_K  = 17'd39797;
  localparam logic [16:0] ONE_Q     = 17'd65536;
  localparam logic [18:0] PI_Q      = 19'd205887;
  localparam logic [18:0] TWO_PI_Q  = 19'd411775;
  localparam logic [18:0] HALF_PI_Q = 19'd102944;

  localparam logic [16:0] ATAN_Q [STEPS] = '{
    17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024,
    17'd512, 17'd256, 17'd128, 17'd64, 17'd32, 17'd16, 17'd8, 17'd4, 17'd2, 17'd1
  };

  localparam logic [1:0] REG_ENABLE   = 2'd0;
  localparam logic [1:0] REG_MAX_TILT = 2'd1;
  localparam logic [1:0] REG_GAIN     = 2'd2;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cord_t;

  typedef struct packed {
    logic [SW-1:0] n;
    logic [SW-1:0] r;
  } sqrt_t;

endpackage

// ===== rtl/tlrc_cordic_cell.sv =====
module tlrc_cordic_cell #(
  parameter int IDX  = 0,
  parameter bit VECT = 1'b0
) (
  input  logic             clk,
  input  logic             en,
  input  tlrc_pkg::cord_t  c_in,
  output tlrc_pkg::cord_t  c_out
);

  localparam logic signed [tlrc_pkg::CW-1:0] AT =
    $signed(tlrc_pkg::CW'(tlrc_pkg::ATAN_Q[IDX]));

  logic signed [tlrc_pkg::CW-1:0] dx;
  logic signed [tlrc_pkg::CW-1:0] dy;
  logic                           pos;

  assign dx  = c_in.y >>> IDX;
  assign dy  = c_in.x >>> IDX;
  // rotation steers on z, vectoring drives y to zero
  assign pos = VECT ? c_in.y[tlrc_pkg::CW-1] : !c_in.z[tlrc_pkg::CW-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (pos) begin
        c_out.x <= c_in.x - dx;
        c_out.y <= c_in.y + dy;
        c_out.z <= c_in.z - AT;
      end else begin
        c_out.x <= c_in.x + dx;
        c_out.y <= c_in.y - dy;
        c_out.z <= c_in.z + AT;
      end
    end
  end

endmodule

// ===== rtl/tlrc_sqrt_cell.sv =====
module tlrc_sqrt_cell #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             en,
  input  tlrc_pkg::sqrt_t  s_in,
  output tlrc_pkg::sqrt_t  s_out
);

  localparam logic [tlrc_pkg::SW-1:0] BIT = tlrc_pkg::SW'(1) << (32 - 2 * IDX);

  logic [tlrc_pkg::SW-1:0] trial;

  assign trial = s_in.r + BIT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (s_in.n >= trial) begin
        s_out.n <= s_in.n - trial;
        s_out.r <= (s_in.r >> 1) + BIT;
      end else begin
        s_out.n <= s_in.n;
        s_out.r <= s_in.r >> 1;
      end
    end
  end

endmodule

// ===== rtl/tilt_limit_rate_correction_top.sv =====
// Tilt limit guard with rate correction.
// Input stream s_*: one attitude sample per request (pitch/roll angle, pitch/roll rate).
// Output stream m_*: one result per sample (active flag, tilt, two rate corrections).
// Config channel cfg_*: index 0 enable, 1 max_tilt, 2 recovery_gain; always ready.
// Write config only while no sample is in flight.
// Throughput: one sample per cycle unless the output stalls; the row of pipeline cells
// (17 sin/cos CORDIC cells, 17 square root cells, 17 vectoring CORDIC cells, plus
// input, camera cosine, radicand, limit check, multiply and output stages) each take a
// new sample every clock.
// Each stage moves on when the next one is empty or moving, so a stalled output
// holds its result while earlier stages keep filling bubbles; s_tready falls only
// once every stage holds a sample.
// Reset clears all stage valid flags and loads enable=0, max_tilt=4289, gain=256.
`include "assert_macros.svh"

module tilt_limit_rate_correction_top #(
  parameter int ANGLE_WIDTH = 16,
  parameter int RATE_WIDTH  = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // pitch_angle, roll_angle, pitch_rate, roll_rate, zero fill
  input  logic [((2*ANGLE_WIDTH+2*RATE_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // active, tilt, pitch_correction, roll_correction, zero fill
  output logic [((ANGLE_WIDTH+2*RATE_WIDTH+11+7)/8)*8-1:0] m_tdata,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [((ANGLE_WIDTH-2) > 16 ? (ANGLE_WIDTH-2) : 16)-1:0] cfg_data
);

  localparam int AW    = ANGLE_WIDTH;
  localparam int RW    = RATE_WIDTH;
  localparam int TW    = AW - 2;
  localparam int CRW   = RW + 6;
  localparam int OUT_W = ((AW+2*RW+11+7)/8)*8;
  localparam int AD    = AW - 19;
  localparam int SHL   = AD < 0 ? -AD : 0;
  localparam int SHR   = AD > 0 ? AD : 0;
  localparam int DW    = AW + 2;
  localparam int PW    = DW + 17;
  localparam int SH    = AW - RW + 12;
  localparam longint RND = SH > 0 ? (longint'(1) << (SH - 1)) : 0;
  localparam longint HI  = (longint'(1) << (CRW - 1)) - 1;
  localparam int NS    = 57;
  localparam int NP    = 54;
  localparam int ST_CAM = 18;
  localparam int ST_SQ  = 19;
  localparam int ST_SQ0 = 20;
  localparam int ST_VC0 = 37;
  localparam int ST_SEL = 54;
  localparam int ST_MUL = 55;
  localparam int ST_OUT = 56;

  typedef struct packed {
    logic signed [AW-1:0] pa;
    logic signed [AW-1:0] ra;
    logic signed [RW-1:0] pr;
    logic signed [RW-1:0] rr;
    logic                 sgt;
    logic [16:0]          cam;
  } pay_t;

  // configuration
  logic          cfg_en;
  logic [TW-1:0] max_tilt;
  logic [15:0]   gain;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_en   <= 1'b0;
      max_tilt <= TW'(4289);
      gain     <= 16'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        tlrc_pkg::REG_ENABLE:   cfg_en   <= cfg_data[0];
        tlrc_pkg::REG_MAX_TILT: max_tilt <= cfg_data[TW-1:0];
        tlrc_pkg::REG_GAIN:     gain     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // flow control
  logic [NS-1:0] vld;
  logic [NS-1:0] rdy;

  always_comb begin
    rdy[NS-1] = !vld[NS-1] || m_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= s_tvalid;
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) vld[i] <= vld[i-1];
      end
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = vld[NS-1];

  // angle magnitude to Q16, folded into [0, pi/2]
  function automatic logic [18:0] fold(input logic signed [AW-1:0] a);
    logic [AW-1:0] mag;
    logic [18:0]   m;
    mag = a[AW-1] ? AW'(-a) : AW'(a);
    m   = 19'(((AW+7)'(mag) << SHL) >> SHR);
    if (m > tlrc_pkg::PI_Q) m = tlrc_pkg::TWO_PI_Q - m;
    if (m > tlrc_pkg::HALF_PI_Q) m = tlrc_pkg::PI_Q - m;
    return m;
  endfunction

  function automatic logic [16:0] clamp1(input logic signed [tlrc_pkg::CW-1:0] v);
    logic [tlrc_pkg::CW-1:0] a;
    a = v[tlrc_pkg::CW-1] ? tlrc_pkg::CW'(-v) : tlrc_pkg::CW'(v);
    return (a > tlrc_pkg::CW'(tlrc_pkg::ONE_Q)) ? tlrc_pkg::ONE_Q : a[16:0];
  endfunction

  pay_t            pay [NP];
  tlrc_pkg::cord_t rot_p [18];
  tlrc_pkg::cord_t rot_r [18];
  tlrc_pkg::sqrt_t sq [18];
  tlrc_pkg::cord_t vc [18];

  logic signed [AW-1:0] in_pa;
  logic signed [AW-1:0] in_ra;

  assign in_pa = s_tdata[AW-1:0];
  assign in_ra = s_tdata[2*AW-1:AW];

  // input stage
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      rot_p[0]   <= '{x: tlrc_pkg::CW'(tlrc_pkg::CORDIC_K), y: '0,
                      z: tlrc_pkg::CW'(fold(in_pa))};
      rot_r[0]   <= '{x: tlrc_pkg::CW'(tlrc_pkg::CORDIC_K), y: '0,
                      z: tlrc_pkg::CW'(fold(in_ra))};
    end
  end

  // payload shift line with the stage that fills in the camera cosine
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      pay[0].pa  <= in_pa;
      pay[0].ra  <= in_ra;
      pay[0].pr  <= s_tdata[2*AW+RW-1:2*AW];
      pay[0].rr  <= s_tdata[2*AW+2*RW-1:2*AW+RW];
      pay[0].sgt <= 1'b0;
      pay[0].cam <= '0;
    end
    for (int i = 1; i < NP; i++) begin
      if (rdy[i] && i != ST_CAM) pay[i] <= pay[i-1];
    end
    if (rdy[ST_CAM]) begin
      pay[ST_CAM] <= '{pa: pay[ST_CAM-1].pa, ra: pay[ST_CAM-1].ra,
                       pr: pay[ST_CAM-1].pr, rr: pay[ST_CAM-1].rr,
                       sgt: clamp1(rot_p[17].y) > clamp1(rot_r[17].y),
                       cam: 17'((34'(clamp1(rot_p[17].x)) *
                                 34'(clamp1(rot_r[17].x))) >> 16)};
    end
  end

  // sin/cos cells, pitch and roll side by side
  for (genvar k = 0; k < tlrc_pkg::STEPS; k++) begin : g_rot
    tlrc_cordic_cell #(.IDX(k), .VECT(1'b0)) u_rot_p (
      .clk(clk), .en(rdy[k+1]), .c_in(rot_p[k]), .c_out(rot_p[k+1])
    );
    tlrc_cordic_cell #(.IDX(k), .VECT(1'b0)) u_rot_r (
      .clk(clk), .en(rdy[k+1]), .c_in(rot_r[k]), .c_out(rot_r[k+1])
    );
  end

  // radicand 1 - cam^2 in Q32
  always_ff @(posedge clk) begin
    if (rdy[ST_SQ]) begin
      sq[0].n <= tlrc_pkg::SW'(64'd4294967296) -
                 tlrc_pkg::SW'(34'(pay[ST_CAM].cam) * 34'(pay[ST_CAM].cam));
      sq[0].r <= '0;
    end
  end

  for (genvar k = 0; k < tlrc_pkg::STEPS; k++) begin : g_sqrt
    tlrc_sqrt_cell #(.IDX(k)) u_sqrt (
      .clk(clk), .en(rdy[ST_SQ0+k]), .s_in(sq[k]), .s_out(sq[k+1])
    );
  end

  assign vc[0] = '{x: tlrc_pkg::CW'(pay[ST_VC0-1].cam),
                   y: tlrc_pkg::CW'(sq[17].r), z: '0};

  for (genvar k = 0; k < tlrc_pkg::STEPS; k++) begin : g_vec
    tlrc_cordic_cell #(.IDX(k), .VECT(1'b1)) u_vec (
      .clk(clk), .en(rdy[ST_VC0+k]), .c_in(vc[k]), .c_out(vc[k+1])
    );
  end

  // tilt, limit check, axis choice and error term
  logic [16:0]           zc;
  logic [TW-1:0]         tilt_c;
  logic                  sel_c;
  logic signed [AW-1:0]  ang_c;
  logic signed [RW-1:0]  base_c;
  logic signed [DW-1:0]  lim_c;
  pay_t                  pz;

  assign pz = pay[ST_SEL-1];

  always_comb begin
    if (vc[17].z[tlrc_pkg::CW-1]) zc = '0;
    else if (vc[17].z > $signed(tlrc_pkg::CW'(tlrc_pkg::HALF_PI_Q))) zc = 17'(tlrc_pkg::HALF_PI_Q);
    else zc = vc[17].z[16:0];
    tilt_c = TW'(((TW+7)'(zc) << SHR) >> SHL);
    sel_c  = pz.sgt;
    ang_c  = sel_c ? pz.pa : pz.ra;
    if (sel_c) begin
      base_c = (pz.pa[AW-1] && !pz.pr[RW-1] && pz.pr != '0) ? pz.pr : '0;
    end else if (!pz.ra[AW-1] && pz.ra != '0) begin
      base_c = pz.rr[RW-1] ? pz.rr : '0;
    end else begin
      base_c = (!pz.rr[RW-1] && pz.rr != '0) ? pz.rr : '0;
    end
    lim_c = $signed(DW'(max_tilt));
    if (ang_c[AW-1] || ang_c == '0) lim_c = -lim_c;
  end

  logic                 t_act;
  logic [TW-1:0]        t_tilt;
  logic                 t_sel;
  logic signed [DW-1:0] t_diff;
  logic signed [RW-1:0] t_base;

  always_ff @(posedge clk) begin
    if (rdy[ST_SEL]) begin
      t_act  <= tilt_c > max_tilt;
      t_tilt <= tilt_c;
      t_sel  <= sel_c;
      t_diff <= lim_c - (DW'(ang_c) <<< 1);
      t_base <= base_c;
    end
  end

  logic                 p_act;
  logic [TW-1:0]        p_tilt;
  logic                 p_sel;
  logic signed [PW-1:0] p_prod;
  logic signed [RW-1:0] p_base;

  always_ff @(posedge clk) begin
    if (rdy[ST_MUL]) begin
      p_act  <= t_act;
      p_tilt <= t_tilt;
      p_sel  <= t_sel;
      p_prod <= PW'(t_diff) * $signed(PW'({1'b0, gain}));
      p_base <= t_base;
    end
  end

  // round half up, add base rate, saturate
  logic signed [PW:0]    rnd_v;
  logic signed [PW:0]    sum_v;
  logic signed [CRW-1:0] corr;

  always_comb begin
    rnd_v = ((PW+1)'(p_prod) + $signed((PW+1)'(RND))) >>> SH;
    sum_v = rnd_v + (PW+1)'(p_base);
    if (sum_v > $signed((PW+1)'(HI))) corr = CRW'(HI);
    else if (sum_v < $signed((PW+1)'(-HI - 1))) corr = CRW'(-HI - 1);
    else corr = CRW'(sum_v);
  end

  logic                  o_act;
  logic [TW-1:0]         o_tilt;
  logic signed [CRW-1:0] o_pc;
  logic signed [CRW-1:0] o_rc;

  always_ff @(posedge clk) begin
    if (rdy[ST_OUT]) begin
      o_act  <= cfg_en && p_act;
      o_tilt <= cfg_en ? p_tilt : '0;
      o_pc   <= (cfg_en && p_act && p_sel) ? corr : '0;
      o_rc   <= (cfg_en && p_act && !p_sel) ? corr : '0;
    end
  end

  assign m_tdata = OUT_W'({o_rc, o_pc, o_tilt, o_act});

  `ASSERT_IMPLY(a_stall_full, clk, rst, !s_tready, m_tvalid && !m_tready)
  `ASSERT_NEXT(a_enter, clk, rst, s_tvalid && s_tready, vld[0])
  `ASSERT_IMPLY(a_idle_zero, clk, rst, m_tvalid && !o_act, o_pc == '0 && o_rc == '0)
  `ASSERT_IMPLY(a_one_axis, clk, rst, m_tvalid && o_pc != '0, o_rc == '0)

endmodule

// ===== tb/tilt_limit_rate_correction_top_test.sv =====
module tilt_limit_rate_correction_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 70;

  typedef struct {
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_rate;
    logic signed [15:0] roll_rate;
  } attitude_t;

  typedef struct {
    logic               active;
    logic [13:0]        tilt;
    logic signed [21:0] pitch_corr;
    logic signed [21:0] roll_corr;
  } guard_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = tlrc_pkg::REG_ENABLE;
  logic [15:0] cfg_data = '0;

  // shadow of the block's registers
  logic        guard_on;
  longint      tilt_limit;
  longint      gain;

  guard_result_t expected_results[$];
  int error_count = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int active_seen = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  tilt_limit_rate_correction_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #3ms;
    $display("timeout waiting for results");
    $display("tilt_limit_rate_correction_top: mismatch");
    $finish;
  end

  // ---------------- predictor ----------------
  function automatic void trig_magnitude(input longint ang, output longint s, output longint c);
    longint m, x, y, z, dx, dy;
    m = (ang < 0) ? -ang : ang;
    m = m <<< 3;  // Q13 -> Q16
    if (m > longint'(tlrc_pkg::PI_Q)) m = longint'(tlrc_pkg::TWO_PI_Q) - m;
    if (m > longint'(tlrc_pkg::HALF_PI_Q)) m = longint'(tlrc_pkg::PI_Q) - m;
    x = longint'(tlrc_pkg::CORDIC_K);
    y = 0;
    z = m;
    for (int i = 0; i < tlrc_pkg::STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(tlrc_pkg::ATAN_Q[i]);
      end else begin
        x += dx; y -= dy; z += longint'(tlrc_pkg::ATAN_Q[i]);
      end
    end
    if (y < 0) y = -y;
    if (x < 0) x = -x;
    s = (y > 65536) ? 65536 : y;
    c = (x > 65536) ? 65536 : x;
  endfunction

  function automatic longint int_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 32;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint camera_tilt(input longint cp, input longint cr);
    longint cam, x, y, z, dx, dy;
    cam = (cp * cr) >>> 16;
    x = cam;
    y = int_sqrt((64'd1 << 32) - longint'(cam * cam));
    z = 0;
    for (int i = 0; i < tlrc_pkg::STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(tlrc_pkg::ATAN_Q[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(tlrc_pkg::ATAN_Q[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(tlrc_pkg::HALF_PI_Q)) z = longint'(tlrc_pkg::HALF_PI_Q);
    return z >>> 3;
  endfunction

  function automatic longint recovery_rate(input longint angle, input longint base);
    longint diff2, p, v;
    diff2 = ((angle > 0) ? tilt_limit : -tilt_limit) - 2 * angle;
    p = (diff2 * gain + 2048) >>> 12;  // round half up to Q10
    v = p + base;
    if (v > 2097151) v = 2097151;
    if (v < -2097152) v = -2097152;
    return v;
  endfunction

  function automatic guard_result_t predict_guard(input attitude_t a);
    guard_result_t r;
    longint sp, cp, sr, cr, tilt, base, corr;
    r = '{default: '0};
    if (!guard_on) return r;
    trig_magnitude(a.pitch_angle, sp, cp);
    trig_magnitude(a.roll_angle, sr, cr);
    tilt = camera_tilt(cp, cr);
    r.tilt = tilt[13:0];
    if (tilt > tilt_limit) begin
      r.active = 1'b1;
      if (sp > sr) begin
        // pitch keeps its base rate only for nose-down attitude
        base = (a.pitch_angle < 0 && a.pitch_rate > 0) ? longint'(a.pitch_rate) : 0;
        corr = recovery_rate(a.pitch_angle, base);
        r.pitch_corr = corr[21:0];
      end else begin
        if (a.roll_angle > 0) base = (a.roll_rate < 0) ? longint'(a.roll_rate) : 0;
        else base = (a.roll_rate > 0) ? longint'(a.roll_rate) : 0;
        corr = recovery_rate(a.roll_angle, base);
        r.roll_corr = corr[21:0];
      end
    end
    return r;
  endfunction

  // ---------------- drivers ----------------
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic send_sample(input attitude_t a);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {a.roll_rate, a.pitch_rate, a.roll_angle, a.pitch_angle};
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(predict_guard(a));
    samples_sent++;
  endtask

  task automatic send_fields(input int pa, input int ra, input int pr, input int rr);
    attitude_t a;
    a.pitch_angle = pa[15:0];
    a.roll_angle = ra[15:0];
    a.pitch_rate = pr[15:0];
    a.roll_rate = rr[15:0];
    send_sample(a);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0)
        // small angles near level, tilt near typical limits
        send_fields($urandom_range(8000) - 4000, $urandom_range(8000) - 4000,
                    $urandom_range(65535) - 32768, $urandom_range(65535) - 32768);
      else
        send_fields($urandom_range(51472) - 25736, $urandom_range(51472) - 25736,
                    $urandom_range(65535) - 32768, $urandom_range(65535) - 32768);
    end
  endtask

  // wait until every request has produced its result, then let the pipe settle
  task automatic drain;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[15:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      tlrc_pkg::REG_ENABLE:   guard_on = value[0];
      tlrc_pkg::REG_MAX_TILT: tilt_limit = longint'(value[13:0]);
      tlrc_pkg::REG_GAIN:     gain = longint'(value[15:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------- checker ----------------
  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("result %0d: %s got %0d expected %0d", results_seen, field, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    guard_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, data", longint'(m_tdata), 0);
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[0] !== want.active)
          report_mismatch("active", m_tdata[0], want.active);
        if (m_tdata[14:1] !== want.tilt)
          report_mismatch("tilt", m_tdata[14:1], want.tilt);
        if (m_tdata[36:15] !== want.pitch_corr)
          report_mismatch("pitch_correction", $signed(m_tdata[36:15]), want.pitch_corr);
        if (m_tdata[58:37] !== want.roll_corr)
          report_mismatch("roll_correction", $signed(m_tdata[58:37]), want.roll_corr);
        if (want.active) active_seen++;
      end
      results_seen++;
    end
  end

  // ---------------- tests ----------------
  task automatic test_disabled_after_reset;
    send_fields(25736, -25736, 32767, -32768);
    send_fields(0, 0, 0, 0);
    send_random(6);
    drain();
  endtask

  task automatic test_directed_corners;
    write_reg(tlrc_pkg::REG_ENABLE, 1);
    send_fields(0, 0, 0, 0);
    send_fields(25736, 25736, 32767, 32767);
    send_fields(-25736, -25736, -32768, -32768);
    send_fields(1, -1, 1, -1);
    send_fields(-12868, 100, 5000, -5000);   // nose down, pitch wins, positive rate kept
    send_fields(12868, 100, 5000, -5000);    // nose up, no pitch base
    send_fields(100, 12868, 3000, -3000);    // roll right, negative rate kept
    send_fields(100, -12868, 3000, -3000);   // roll left, negative rate dropped
    send_fields(6000, 6000, 1000, 1000);     // equal magnitude, roll takes it
    send_fields(-6000, 6000, -1000, 1000);
    send_fields(25000, 3000, 0, 0);          // past pi/2, folded
    send_fields(-20000, -24000, 32767, -32768);
    drain();
  endtask

  task automatic test_register_extremes;
    write_reg(REG_UNUSED, 16'hFFFF);         // ignored
    write_reg(tlrc_pkg::REG_MAX_TILT, 0);
    write_reg(tlrc_pkg::REG_GAIN, 65535);
    send_fields(-25736, 25736, 32767, -32768);
    send_fields(1, 1, -32768, 32767);
    send_random(12);
    drain();
    write_reg(tlrc_pkg::REG_MAX_TILT, 12868);  // limit at pi/2, never active
    write_reg(tlrc_pkg::REG_GAIN, 0);
    send_fields(12868, 12868, 100, 100);
    send_random(8);
    drain();
  endtask

  task automatic test_random_phase(input int tx_pct, input int rx_pct, input int count);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    write_reg(tlrc_pkg::REG_MAX_TILT, $urandom_range(6000));
    write_reg(tlrc_pkg::REG_GAIN, $urandom_range(65535));
    send_random(count / 2);
    drain();
    write_reg(tlrc_pkg::REG_MAX_TILT, $urandom_range(12868));
    write_reg(tlrc_pkg::REG_GAIN, $urandom_range(2048));
    send_random(count / 2);
    drain();
  endtask

  initial begin
    guard_on = 1'b0;
    tilt_limit = 4289;
    gain = 256;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    tx_idle_pct = 18;
    rx_idle_pct = 85;
    test_disabled_after_reset();
    test_directed_corners();
    test_register_extremes();
    test_random_phase(18, 85, 120);
    test_random_phase(85, 18, 120);
    test_random_phase(0, 0, 120);
    write_reg(tlrc_pkg::REG_ENABLE, 0);
    send_random(10);
    drain();
    $display("sent %0d attitude samples, checked %0d results, %0d with guard active",
             samples_sent, results_seen, active_seen);
    $display("covered disabled guard, limit and gain extremes, and three stall patterns");
    if (error_count == 0 && expected_results.size() == 0)
      $display("tilt_limit_rate_correction_top: match");
    else
      $display("tilt_limit_rate_correction_top: mismatch");
    $finish;
  end

endmodule
